FILE: design/tmsr_pkg.sv
// Package for the text-mode scanline renderer: sizes, command codes and field constants.
`timescale 1ns / 1ps
package tmsr_pkg;

	localparam int COLUMNS      = 50;
	localparam int ROWS         = 20;
	localparam int GLYPH_HEIGHT = 12;

	localparam int TXT_DEPTH  = ROWS * COLUMNS;
	localparam int TXT_AW     = (TXT_DEPTH > 1) ? $clog2(TXT_DEPTH) : 1;
	localparam int RB_W       = $clog2(TXT_DEPTH + 1);
	localparam int FONT_DEPTH = GLYPH_HEIGHT * 256;
	localparam int FONT_AW    = $clog2(FONT_DEPTH);

	localparam logic [9:0] FIRST_ACTIVE_RESET = 10'd38;
	localparam logic [6:0] LINE_BASE          = 7'd21;
	localparam logic [6:0] POS_SWAP           = 7'h03;
	localparam logic [7:0] INVERT_MASK        = 8'hff;
	localparam int         BLINK_BIT          = 4;

	typedef enum logic [1:0] {
		CMD_TEXT   = 2'd0,
		CMD_FONT   = 2'd1,
		CMD_FIELD  = 2'd2,
		CMD_RENDER = 2'd3
	} cmd_t;

endpackage

FILE: design/tmsr_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
`timescale 1ns / 1ps
module tmsr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: design/text_mode_scanline_renderer.sv
// Text-mode scanline renderer: command decode, render sequencer and output register.
//
// Usage: commands arrive on the s_ stream (s_tuser carries the command code, s_tdata
// the cell, font and cursor fields). Text cell writes, font byte writes and field
// starts complete when accepted. A render command produces COLUMNS pixel bytes on the
// m_ stream, with m_tlast on the final byte of the line.
// Render pipeline: a three-stage fetch (text read, font read, output register) steps
// one column per cycle while the receiver does not stall. After the command is
// accepted, issue_q is set and each column passes the text RAM read register, the
// font RAM read register and the output register in that order. The next command
// can be taken in the cycle after the last byte is taken.
// s_tready stays low for the whole render.
// When the receiver stalls, the fetch stages and the RAM read registers hold and
// resume with no byte lost.
// Reset: all counters clear, first_active_line returns to 38 and the text store is
// cleared over all ROWS * COLUMNS entries (1000 by default), one entry per cycle,
// with s_tready low. Writes on cfg_wr_en are taken at any time and must be made only
// while no render is running.
`timescale 1ns / 1ps
module text_mode_scanline_renderer
	import tmsr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration: first_active_line
	input  logic        cfg_wr_en,
	input  logic [9:0]  cfg_wr_data,
	// s_tuser: cmd[1:0]
	// s_tdata: text_row[4:0], text_col[10:5], char_code[18:11], glyph_row[22:19],
	//          glyph_bits[30:23], cursor_col[38:31], cursor_row[46:39], zero[47]
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,
	input  logic [47:0] s_tdata,
	// m_tdata: byte_pos[6:0], pixels[14:7], zero[15]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,
	output logic        m_tlast
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RENDER
	} state_t;

	state_t state_q;

	logic [9:0]        first_active_q;
	logic [15:0]       scan_q;
	logic [3:0]        glyph_q;
	logic [4:0]        trow_q;
	logic [RB_W-1:0]   row_base_q;
	logic [7:0]        blink_q;
	logic [TXT_AW-1:0] clr_q;

	logic              issue_q;
	logic [5:0]        col_q;
	logic              v_s1;
	logic [5:0]        col_s1;
	logic              v_s2;
	logic [5:0]        col_s2;
	logic [7:0]        ccol_q;
	logic [7:0]        crow_q;

	logic              m_valid_q;
	logic [6:0]        byte_pos_q;
	logic [7:0]        pix_q;
	logic              last_q;

	// input fields
	logic [4:0] s_text_row;
	logic [5:0] s_text_col;
	logic [7:0] s_char_code;
	logic [3:0] s_glyph_row;
	logic [7:0] s_glyph_bits;
	logic [7:0] s_cursor_col;
	logic [7:0] s_cursor_row;
	cmd_t       s_cmd;

	assign s_cmd        = cmd_t'(s_tuser);
	assign s_text_row   = s_tdata[4:0];
	assign s_text_col   = s_tdata[10:5];
	assign s_char_code  = s_tdata[18:11];
	assign s_glyph_row  = s_tdata[22:19];
	assign s_glyph_bits = s_tdata[30:23];
	assign s_cursor_col = s_tdata[38:31];
	assign s_cursor_row = s_tdata[46:39];

	logic        in_xfer;
	logic        out_xfer;
	logic        adv;
	logic        active;
	logic [15:0] cell_addr;
	logic [RB_W-1:0] rd_sum;

	logic              txt_we;
	logic [TXT_AW-1:0] txt_waddr;
	logic [7:0]        txt_wdata;
	logic              txt_re;
	logic [TXT_AW-1:0] txt_raddr;
	logic [7:0]        txt_rdata;

	logic               font_we;
	logic [FONT_AW-1:0] font_waddr;
	logic               font_re;
	logic [FONT_AW-1:0] font_raddr;
	logic [7:0]         font_rdata;
	logic [11:0]        font_wfull;
	logic [11:0]        font_rfull;

	logic [7:0] px;
	logic       on_cursor;

	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign out_xfer = m_valid_q && m_tready;
	assign adv      = !m_valid_q || m_tready;

	assign active = (scan_q >= 16'(first_active_q)) && (32'(trow_q) < ROWS);

	// text store: clearing pass after reset, else cell writes
	assign cell_addr = 16'(s_text_row) * 16'(COLUMNS) + 16'(s_text_col);
	assign txt_we    = (state_q == ST_CLEAR) ||
	                   (in_xfer && s_cmd == CMD_TEXT &&
	                    32'(s_text_row) < ROWS && 32'(s_text_col) < COLUMNS);
	assign txt_waddr = (state_q == ST_CLEAR) ? clr_q : cell_addr[TXT_AW-1:0];
	assign txt_wdata = (state_q == ST_CLEAR) ? 8'd0 : s_char_code;

	assign rd_sum    = row_base_q + RB_W'(col_q);
	assign txt_raddr = rd_sum[TXT_AW-1:0];
	assign txt_re    = adv && issue_q;

	assign font_wfull = {s_glyph_row, s_char_code};
	assign font_we    = in_xfer && s_cmd == CMD_FONT && 32'(s_glyph_row) < GLYPH_HEIGHT;
	assign font_waddr = font_wfull[FONT_AW-1:0];
	assign font_rfull = {glyph_q, txt_rdata};
	assign font_raddr = font_rfull[FONT_AW-1:0];
	assign font_re    = adv && v_s1;

	tmsr_ram #(.WIDTH(8), .DEPTH(TXT_DEPTH)) u_text_ram (
		.clk   (clk),
		.we    (txt_we),
		.waddr (txt_waddr),
		.wdata (txt_wdata),
		.re    (txt_re),
		.raddr (txt_raddr),
		.rdata (txt_rdata)
	);

	tmsr_ram #(.WIDTH(8), .DEPTH(FONT_DEPTH)) u_font_ram (
		.clk   (clk),
		.we    (font_we),
		.waddr (font_waddr),
		.wdata (s_glyph_bits),
		.re    (font_re),
		.raddr (font_raddr),
		.rdata (font_rdata)
	);

	// status line and blinking cursor invert the glyph row
	assign on_cursor = (crow_q == {3'd0, trow_q}) && (ccol_q == {2'd0, col_s2}) &&
	                   blink_q[BLINK_BIT];

	always_comb begin
		px = 8'd0;
		if (active) begin
			px = font_rdata;
			if (trow_q == 5'd0) begin
				px = px ^ INVERT_MASK;
			end
			if (on_cursor) begin
				px = px ^ INVERT_MASK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			first_active_q <= FIRST_ACTIVE_RESET;
			scan_q         <= '0;
			glyph_q        <= '0;
			trow_q         <= '0;
			row_base_q     <= '0;
			blink_q        <= '0;
			clr_q          <= '0;
			issue_q        <= 1'b0;
			col_q          <= '0;
			v_s1           <= 1'b0;
			col_s1         <= '0;
			v_s2           <= 1'b0;
			col_s2         <= '0;
			ccol_q         <= '0;
			crow_q         <= '0;
			m_valid_q      <= 1'b0;
			byte_pos_q     <= '0;
			pix_q          <= '0;
			last_q         <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				first_active_q <= cfg_wr_data;
			end

			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == TXT_DEPTH - 1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_xfer) begin
						case (s_cmd)
							CMD_FIELD: begin
								scan_q     <= '0;
								glyph_q    <= '0;
								trow_q     <= '0;
								row_base_q <= '0;
								blink_q    <= blink_q + 1'b1;
							end
							CMD_RENDER: begin
								state_q <= ST_RENDER;
								issue_q <= 1'b1;
								col_q   <= '0;
								ccol_q  <= s_cursor_col;
								crow_q  <= s_cursor_row;
							end
							default: begin
							end
						endcase
					end
				end
				ST_RENDER: begin
					if (adv) begin
						v_s1      <= issue_q;
						col_s1    <= col_q;
						v_s2      <= v_s1;
						col_s2    <= col_s1;
						m_valid_q <= v_s2;
						if (v_s2) begin
							byte_pos_q <= (LINE_BASE + {1'b0, col_s2}) ^ POS_SWAP;
							pix_q      <= px;
							last_q     <= (32'(col_s2) == COLUMNS - 1);
						end
						if (issue_q) begin
							if (32'(col_q) == COLUMNS - 1) begin
								issue_q <= 1'b0;
							end else begin
								col_q <= col_q + 1'b1;
							end
						end
					end
					// advance line counters once the last byte is taken
					if (out_xfer && last_q) begin
						state_q <= ST_IDLE;
						if (active) begin
							if (32'(glyph_q) == GLYPH_HEIGHT - 1) begin
								glyph_q    <= '0;
								trow_q     <= trow_q + 1'b1;
								row_base_q <= row_base_q + RB_W'(COLUMNS);
							end else begin
								glyph_q <= glyph_q + 1'b1;
							end
						end
						if (scan_q != 16'hffff) begin
							scan_q <= scan_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {1'b0, pix_q, byte_pos_q};
	assign m_tlast  = last_q;

`ifndef NO_ASSERTIONS
	a_out_only_render: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (state_q == ST_RENDER))
		else $error("output valid outside a render");

	a_render_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && s_cmd == CMD_RENDER) |=> (state_q == ST_RENDER && issue_q))
		else $error("render command did not start the sequencer");

	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |->
		(m_tdata[6:0] == ((LINE_BASE + 7'(COLUMNS - 1)) ^ POS_SWAP)))
		else $error("last flag on a byte that is not the final column");

	a_glyph_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(glyph_q) < GLYPH_HEIGHT)
		else $error("glyph line out of range");
`endif

endmodule
